### rtl/core/nts_pkg.sv
// package for the station table with aging eviction
// item structs, controller command/status structs, outcome codes and defaults
// no dependencies
package nts_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 16;
    localparam int unsigned ADDR_W          = 48;
    localparam int unsigned TIME_W          = 48;
    localparam int unsigned TIMEOUT_W       = 32;
    localparam int unsigned SLOT_W          = 4;
    localparam int unsigned CODE_W          = 2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd2000000;

    localparam logic [CODE_W-1:0] OUT_MATCH = 2'd0;
    localparam logic [CODE_W-1:0] OUT_FREE  = 2'd1;
    localparam logic [CODE_W-1:0] OUT_EVICT = 2'd2;
    localparam logic [CODE_W-1:0] OUT_DROP  = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] station_address;
        logic [TIME_W-1:0] now_us;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic [CODE_W-1:0] outcome;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic issue;
        logic commit;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic idx_last;
    } dp_status_t;

endpackage

### rtl/core/nts_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module nts_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

### rtl/core/nts_ctrl.sv
// controller for the station table: accept, walk, commit and result hand-off
// depends on nts_pkg
module nts_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output nts_pkg::ctrl_cmd_t cmd,
    input  nts_pkg::dp_status_t st
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_LAST   = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.issue = 1'b1;
                if (st.idx_last) begin
                    state_next = S_LAST;
                end
            end
            // last read data is evaluated here
            S_LAST: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> out_free)
        else $error("result loaded over an item not yet taken");

endmodule

### rtl/core/nts_dp.sv
// datapath for the station table: valid bits, address and time rams,
// walk counter, match/free/oldest-stale trackers and result registers
// depends on nts_pkg and nts_ram
module nts_dp #(
    parameter int unsigned TABLE_DEPTH = nts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [nts_pkg::TIMEOUT_W-1:0]    cfg_wr_data,
    input  nts_pkg::in_item_t                s_item,
    output nts_pkg::out_item_t               m_item,
    input  nts_pkg::ctrl_cmd_t               cmd,
    output nts_pkg::dp_status_t              st
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

    logic [nts_pkg::TIMEOUT_W-1:0] timeout_reg;
    nts_pkg::in_item_t             in_reg;
    logic [TABLE_DEPTH-1:0]        valid_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic                          pend_reg;
    logic [IDX_W-1:0]              pidx_reg;
    logic                          pvalid_reg;

    logic                          match_found_reg;
    logic [IDX_W-1:0]              match_idx_reg;
    logic                          free_found_reg;
    logic [IDX_W-1:0]              free_idx_reg;
    logic                          stale_have_reg;
    logic [IDX_W-1:0]              stale_idx_reg;
    logic [nts_pkg::TIME_W-1:0]    oldest_reg;

    nts_pkg::out_item_t            res_reg;
    nts_pkg::out_item_t            m_item_reg;

    logic [nts_pkg::ADDR_W-1:0]    addr_rd;
    logic [nts_pkg::TIME_W-1:0]    time_rd;
    logic [nts_pkg::TIME_W-1:0]    seen;
    logic [nts_pkg::TIME_W-1:0]    elapsed;
    logic                          addr_hit;
    logic                          stale;
    logic                          older;

    logic [IDX_W-1:0]              pick;
    logic [nts_pkg::CODE_W-1:0]    code;
    logic                          do_write;

    assign st.idx_last = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign m_item      = m_item_reg;

    nts_ram #(
        .WIDTH (nts_pkg::ADDR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_addr_ram (
        .aclk  (aclk),
        .we    (do_write),
        .waddr (pick),
        .wdata (in_reg.station_address),
        .raddr (idx_reg),
        .rdata (addr_rd)
    );

    nts_ram #(
        .WIDTH (nts_pkg::TIME_W),
        .DEPTH (TABLE_DEPTH)
    ) u_time_ram (
        .aclk  (aclk),
        .we    (do_write),
        .waddr (pick),
        .wdata (in_reg.now_us),
        .raddr (idx_reg),
        .rdata (time_rd)
    );

    // an entry never written reads as time zero
    assign seen     = pvalid_reg ? time_rd : '0;
    assign addr_hit = pvalid_reg && (addr_rd == in_reg.station_address);
    assign elapsed  = in_reg.now_us - seen;
    // time going backwards counts as no time elapsed
    assign stale    = (in_reg.now_us > seen) &&
                      (elapsed > nts_pkg::TIME_W'(timeout_reg));
    assign older    = !stale_have_reg || (seen < oldest_reg);

    always_comb begin
        pick = '0;
        code = nts_pkg::OUT_DROP;
        if (match_found_reg) begin
            pick = match_idx_reg;
            code = nts_pkg::OUT_MATCH;
        end else if (free_found_reg) begin
            pick = free_idx_reg;
            code = nts_pkg::OUT_FREE;
        end else if (stale_have_reg) begin
            pick = stale_idx_reg;
            code = nts_pkg::OUT_EVICT;
        end
    end

    assign do_write = cmd.commit && (code != nts_pkg::OUT_DROP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= nts_pkg::TIMEOUT_RESET;
            valid_reg   <= '0;
            pend_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            if (do_write) begin
                valid_reg[pick] <= 1'b1;
            end
            pend_reg <= cmd.issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg          <= s_item;
            idx_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            stale_have_reg  <= 1'b0;
        end else begin
            if (cmd.issue) begin
                idx_reg    <= idx_reg + 1'b1;
                pidx_reg   <= idx_reg;
                pvalid_reg <= valid_reg[idx_reg];
            end
            if (pend_reg) begin
                if (addr_hit && !match_found_reg) begin
                    match_found_reg <= 1'b1;
                    match_idx_reg   <= pidx_reg;
                end
                if (!pvalid_reg && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= pidx_reg;
                end
                // strict compare keeps the lower index on a tie
                if (stale && older) begin
                    stale_have_reg <= 1'b1;
                    stale_idx_reg  <= pidx_reg;
                    oldest_reg     <= seen;
                end
            end
        end
        if (cmd.commit) begin
            res_reg.slot_index <= nts_pkg::SLOT_W'(pick);
            res_reg.outcome    <= code;
        end
        if (cmd.load_out) begin
            m_item_reg <= res_reg;
        end
    end

    a_match_is_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && match_found_reg |-> valid_reg[match_idx_reg])
        else $error("match reported on an entry that is not valid");

    a_free_is_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && !match_found_reg && free_found_reg |-> !valid_reg[free_idx_reg])
        else $error("free slot taken over a valid entry");

    a_write_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        do_write |=> valid_reg[$past(pick)])
        else $error("committed slot not marked valid");

endmodule

### rtl/core/node_table_stale_eviction.sv
// Station table with aging eviction. Each input item is a frame arrival with a
// 48-bit station address and the current time in microseconds; the result item
// gives the slot used and the outcome (existing match, free slot taken, stale
// entry evicted, dropped). Between accepts, a single walk over the table reads
// the address and time memories one entry per cycle through their one read port,
// followed by an evaluate, a commit, a result hand-off and an idle state in which
// the next item is taken. The hand-off waits for as long as the previous result
// still sits unaccepted on the output, so a slow m_ready adds its stall cycles to
// the item. The next item is accepted while the previous result still waits on
// m_ready. The presence timeout is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while idle; the block itself does not enforce it.
// Holds the top level; depends on nts_pkg, nts_ctrl, nts_dp and nts_ram.
module node_table_stale_eviction #(
    parameter int unsigned TABLE_DEPTH = nts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [nts_pkg::TIMEOUT_W-1:0] cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  nts_pkg::in_item_t             s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output nts_pkg::out_item_t            m_item
);

    nts_pkg::ctrl_cmd_t  cmd;
    nts_pkg::dp_status_t st;

    nts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .st      (st)
    );

    nts_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_item      (s_item),
        .m_item      (m_item),
        .cmd         (cmd),
        .st          (st)
    );

endmodule
